>>> sv/assert_macros.svh
// Assertion macros shared by the two-queue cache policy RTL.
// Depends on nothing; the including module supplies clk and rst_n.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
// Checked on every rising edge outside of reset.
`define TQC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Checked on every rising edge, reset included.
`define TQC_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define TQC_ASSERT(lbl, prop, msg)
`define TQC_ASSERT_ALWAYS(lbl, prop, msg)
`endif
`endif

>>> sv/tqc_pkg.sv
`timescale 1ns / 1ps
// Shared constants, types and helper functions for the two-queue cache policy.
// Depends on nothing; imported by tqc_cfg and two_queue_cache_policy.
package tqc_pkg;

  localparam int FRESH_DEPTH = 16;
  localparam int GHOST_DEPTH = 32;
  localparam int HOT_DEPTH   = 64;
  localparam int KEY_BITS    = 32;

  // All three stores share one memory, laid out back to back.
  localparam int TOTAL_DEPTH = FRESH_DEPTH + GHOST_DEPTH + HOT_DEPTH;
  localparam int ADDR_W      = (TOTAL_DEPTH > 1) ? $clog2(TOTAL_DEPTH) : 1;
  localparam int FRESH_BASE  = 0;
  localparam int GHOST_BASE  = FRESH_DEPTH;
  localparam int HOT_BASE    = FRESH_DEPTH + GHOST_DEPTH;

  // Index and count width: enough to hold the largest depth itself.
  localparam int MAX_FG    = (FRESH_DEPTH > GHOST_DEPTH) ? FRESH_DEPTH : GHOST_DEPTH;
  localparam int MAX_DEPTH = (MAX_FG > HOT_DEPTH) ? MAX_FG : HOT_DEPTH;
  localparam int IDX_W     = $clog2(MAX_DEPTH + 1);

  // Configuration register widths and reset values.
  localparam int FRESH_CAP_W = 5;
  localparam int GHOST_CAP_W = 6;
  localparam int HOT_CAP_W   = 7;
  localparam logic [FRESH_CAP_W-1:0] FRESH_CAP_RST = 5'd16;
  localparam logic [GHOST_CAP_W-1:0] GHOST_CAP_RST = 6'd32;
  localparam logic [HOT_CAP_W-1:0]   HOT_CAP_RST   = 7'd64;

  // Configuration port.
  localparam int CFG_ADDR_W = 4;
  localparam logic [1:0] REG_FRESH_CAP = 2'd0;
  localparam logic [1:0] REG_GHOST_CAP = 2'd1;
  localparam logic [1:0] REG_HOT_CAP   = 2'd2;

  // Hit place codes.
  localparam logic [1:0] PLACE_MISS  = 2'd0;
  localparam logic [1:0] PLACE_FRESH = 2'd1;
  localparam logic [1:0] PLACE_GHOST = 2'd2;
  localparam logic [1:0] PLACE_HOT   = 2'd3;

  typedef struct packed {
    logic [IDX_W-1:0] fresh;
    logic [IDX_W-1:0] ghost;
    logic [IDX_W-1:0] hot;
  } caps_t;

  typedef enum logic [1:0] {
    STORE_FRESH,
    STORE_GHOST,
    STORE_HOT
  } store_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SEARCH,
    ST_REMOVE,
    ST_INS_INIT,
    ST_INSERT,
    ST_DONE
  } state_t;

  // A capacity of zero acts as one; anything above the depth saturates.
  function automatic logic [IDX_W-1:0] clamp_cap(input logic [HOT_CAP_W-1:0] v,
                                                 input int depth);
    logic [IDX_W-1:0] res;
    if (v == '0) begin
      res = IDX_W'(1);
    end else if (int'(v) > depth) begin
      res = IDX_W'(depth);
    end else begin
      res = IDX_W'(v);
    end
    return res;
  endfunction

endpackage

>>> sv/tqc_ram.sv
`timescale 1ns / 1ps
// Generic single-write, single-read synchronous RAM with registered read data.
// Depends on nothing; holds the key stores of the block.
module tqc_ram #(
  parameter int DEPTH = 112,
  parameter int WIDTH = 32
) (
  input  logic                             clk,
  input  logic                             we,
  input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] waddr,
  input  logic [WIDTH-1:0]                 wdata,
  input  logic                             re,
  input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] raddr,
  output logic [WIDTH-1:0]                 rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Read port; read data is registered.
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

>>> sv/tqc_cfg.sv
`timescale 1ns / 1ps
// APB-style register block holding the three store capacities.
// Depends on tqc_pkg; hands clamped capacities to the controller.
module tqc_cfg (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [tqc_pkg::CFG_ADDR_W-1:0] paddr,
  input  logic [31:0]                    pwdata,
  output logic [31:0]                    prdata,
  output logic                           pready,
  output tqc_pkg::caps_t                 caps
);
  import tqc_pkg::*;

  logic [FRESH_CAP_W-1:0] fresh_cap_r;
  logic [GHOST_CAP_W-1:0] ghost_cap_r;
  logic [HOT_CAP_W-1:0]   hot_cap_r;
  logic                   wr_en;
  logic [1:0]             reg_idx;

  assign pready  = 1'b1;
  assign reg_idx = paddr[3:2];
  assign wr_en   = psel && penable && pwrite;

  // Register writes; unknown addresses are ignored.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fresh_cap_r <= FRESH_CAP_RST;
      ghost_cap_r <= GHOST_CAP_RST;
      hot_cap_r   <= HOT_CAP_RST;
    end else if (wr_en) begin
      if (reg_idx == REG_FRESH_CAP) begin
        fresh_cap_r <= pwdata[FRESH_CAP_W-1:0];
      end
      if (reg_idx == REG_GHOST_CAP) begin
        ghost_cap_r <= pwdata[GHOST_CAP_W-1:0];
      end
      if (reg_idx == REG_HOT_CAP) begin
        hot_cap_r <= pwdata[HOT_CAP_W-1:0];
      end
    end
  end

  // Read mux.
  always_comb begin
    prdata = '0;
    if (reg_idx == REG_FRESH_CAP) begin
      prdata = 32'(fresh_cap_r);
    end else if (reg_idx == REG_GHOST_CAP) begin
      prdata = 32'(ghost_cap_r);
    end else if (reg_idx == REG_HOT_CAP) begin
      prdata = 32'(hot_cap_r);
    end
  end

  // Effective capacities as the controller uses them.
  assign caps.fresh = clamp_cap(HOT_CAP_W'(fresh_cap_r), FRESH_DEPTH);
  assign caps.ghost = clamp_cap(HOT_CAP_W'(ghost_cap_r), GHOST_DEPTH);
  assign caps.hot   = clamp_cap(hot_cap_r, HOT_DEPTH);

endmodule

>>> sv/two_queue_cache_policy.sv
`timescale 1ns / 1ps
// Two-queue (2Q) cache policy: one key per word, one result word per key.
// Steps: the hot, ghost and fresh stores are searched entry by entry, each shift
// moves entries one by one, a setup state precedes each insertion and a result
// state ends the key; the longest path is a miss with all stores full. One key at
// a time: busy drops after the result, and a new word is accepted only while busy
// is low. The result strobe cannot be stalled.
// Reset is synchronous: counts clear and capacities return to 16, 32, 64.
module two_queue_cache_policy (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           start,
  output logic                           busy,
  input  logic signed [31:0]             in_key,
  output logic                           out_strobe,
  output logic                           out_hit,
  output logic [1:0]                     out_hit_place,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [tqc_pkg::CFG_ADDR_W-1:0] paddr,
  input  logic [31:0]                    pwdata,
  output logic [31:0]                    prdata,
  output logic                           pready
);
  import tqc_pkg::*;

  `include "assert_macros.svh"

  caps_t caps;

  state_t               state_r, state_nxt;
  store_t               st_r, st_nxt;
  logic [KEY_BITS-1:0]  key_r, key_nxt;
  logic [KEY_BITS-1:0]  ins_val_r, ins_val_nxt;
  logic [KEY_BITS-1:0]  ev_val_r, ev_val_nxt;
  logic                 evict_r, evict_nxt;
  logic                 more_r, more_nxt;
  logic [IDX_W-1:0]     j_r, j_nxt;
  logic                 rd_v_r, rd_v_nxt;
  logic [IDX_W-1:0]     rd_j_r, rd_j_nxt;
  logic [1:0]           place_r, place_nxt;
  logic [IDX_W-1:0]     fresh_cnt_r, ghost_cnt_r, hot_cnt_r;

  logic                 cnt_we;
  logic [IDX_W-1:0]     cnt_new;
  logic [IDX_W-1:0]     n_cur, c_cur;
  logic [ADDR_W-1:0]    base;

  logic                 mem_we, mem_re;
  logic [ADDR_W-1:0]    mem_waddr, mem_raddr;
  logic [KEY_BITS-1:0]  mem_wdata, mem_rdata;

  logic                 search_hit, search_end, remove_end, insert_end;

  tqc_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .caps    (caps)
  );

  tqc_ram #(
    .DEPTH (TOTAL_DEPTH),
    .WIDTH (KEY_BITS)
  ) u_ram (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  // Count, capacity and base address of the store being worked on.
  always_comb begin
    unique case (st_r)
      STORE_FRESH: begin
        n_cur = fresh_cnt_r;
        c_cur = caps.fresh;
        base  = ADDR_W'(FRESH_BASE);
      end
      STORE_GHOST: begin
        n_cur = ghost_cnt_r;
        c_cur = caps.ghost;
        base  = ADDR_W'(GHOST_BASE);
      end
      STORE_HOT: begin
        n_cur = hot_cnt_r;
        c_cur = caps.hot;
        base  = ADDR_W'(HOT_BASE);
      end
      default: begin
        n_cur = '0;
        c_cur = IDX_W'(1);
        base  = '0;
      end
    endcase
  end

  // Phase end conditions shared by the state and datapath logic.
  assign search_hit = rd_v_r && (mem_rdata == key_r);
  assign search_end = !rd_v_r && (j_r >= n_cur);
  assign remove_end = !rd_v_r && (j_r >= n_cur);
  assign insert_end = !more_r && !rd_v_r;

  // Next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (start) begin
          state_nxt = ST_SEARCH;
        end
      end
      ST_SEARCH: begin
        if (search_hit) begin
          state_nxt = (st_r == STORE_FRESH) ? ST_DONE : ST_REMOVE;
        end else if (search_end && st_r == STORE_FRESH) begin
          state_nxt = ST_INS_INIT;
        end
      end
      ST_REMOVE: begin
        if (remove_end) begin
          state_nxt = ST_INS_INIT;
        end
      end
      ST_INS_INIT: begin
        state_nxt = ST_INSERT;
      end
      ST_INSERT: begin
        if (insert_end) begin
          state_nxt = (st_r == STORE_FRESH && evict_r) ? ST_INS_INIT : ST_DONE;
        end
      end
      ST_DONE: begin
        state_nxt = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Datapath: memory accesses and working registers.
  always_comb begin
    st_nxt      = st_r;
    key_nxt     = key_r;
    ins_val_nxt = ins_val_r;
    ev_val_nxt  = ev_val_r;
    evict_nxt   = evict_r;
    more_nxt    = more_r;
    j_nxt       = j_r;
    rd_v_nxt    = 1'b0;
    rd_j_nxt    = rd_j_r;
    place_nxt   = place_r;
    cnt_we      = 1'b0;
    cnt_new     = n_cur;
    mem_re      = 1'b0;
    mem_raddr   = base + ADDR_W'(j_r);
    mem_we      = 1'b0;
    mem_waddr   = base;
    mem_wdata   = mem_rdata;
    unique case (state_r)
      ST_IDLE: begin
        if (start) begin
          key_nxt = in_key;
          st_nxt  = STORE_HOT;
          j_nxt   = '0;
        end
      end
      ST_SEARCH: begin
        // Stream reads one entry a cycle and compare what comes back.
        if (!search_hit && j_r < n_cur) begin
          mem_re   = 1'b1;
          rd_v_nxt = 1'b1;
          rd_j_nxt = j_r;
          j_nxt    = j_r + IDX_W'(1);
        end
        if (search_hit) begin
          j_nxt = rd_j_r + IDX_W'(1);
          unique case (st_r)
            STORE_HOT:   place_nxt = PLACE_HOT;
            STORE_GHOST: place_nxt = PLACE_GHOST;
            default:     place_nxt = PLACE_FRESH;
          endcase
        end else if (search_end) begin
          j_nxt = '0;
          unique case (st_r)
            STORE_HOT:   st_nxt = STORE_GHOST;
            STORE_GHOST: st_nxt = STORE_FRESH;
            default: begin
              place_nxt   = PLACE_MISS;
              ins_val_nxt = key_r;
            end
          endcase
        end
      end
      ST_REMOVE: begin
        // Close the gap: each entry above the hit moves one place down.
        if (j_r < n_cur) begin
          mem_re   = 1'b1;
          rd_v_nxt = 1'b1;
          rd_j_nxt = j_r;
          j_nxt    = j_r + IDX_W'(1);
        end
        if (rd_v_r) begin
          mem_we    = 1'b1;
          mem_waddr = base + ADDR_W'(rd_j_r - IDX_W'(1));
        end
        if (remove_end) begin
          cnt_we      = 1'b1;
          cnt_new     = n_cur - IDX_W'(1);
          st_nxt      = STORE_HOT;
          ins_val_nxt = key_r;
        end
      end
      ST_INS_INIT: begin
        // A full store gives up the entry at capacity minus one.
        evict_nxt = (n_cur >= c_cur);
        more_nxt  = (n_cur >= c_cur) || (n_cur != '0);
        j_nxt     = (n_cur >= c_cur) ? (c_cur - IDX_W'(1)) : (n_cur - IDX_W'(1));
      end
      ST_INSERT: begin
        // Shift entries up from the oldest, then write the new word at front.
        if (more_r) begin
          mem_re   = 1'b1;
          rd_v_nxt = 1'b1;
          rd_j_nxt = j_r;
          if (j_r == '0) begin
            more_nxt = 1'b0;
          end else begin
            j_nxt = j_r - IDX_W'(1);
          end
        end
        if (rd_v_r) begin
          if (evict_r && rd_j_r == c_cur - IDX_W'(1)) begin
            ev_val_nxt = mem_rdata;
          end else begin
            mem_we    = 1'b1;
            mem_waddr = base + ADDR_W'(rd_j_r + IDX_W'(1));
          end
        end
        if (insert_end) begin
          mem_we    = 1'b1;
          mem_waddr = base;
          mem_wdata = ins_val_r;
          cnt_we    = 1'b1;
          cnt_new   = evict_r ? c_cur : (n_cur + IDX_W'(1));
          if (st_r == STORE_FRESH && evict_r) begin
            st_nxt      = STORE_GHOST;
            ins_val_nxt = ev_val_r;
          end
        end
      end
      ST_DONE: begin
      end
      default: begin
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      rd_v_r      <= 1'b0;
      more_r      <= 1'b0;
      fresh_cnt_r <= '0;
      ghost_cnt_r <= '0;
      hot_cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      rd_v_r  <= rd_v_nxt;
      more_r  <= more_nxt;
      if (cnt_we) begin
        unique case (st_r)
          STORE_FRESH: fresh_cnt_r <= cnt_new;
          STORE_GHOST: ghost_cnt_r <= cnt_new;
          STORE_HOT:   hot_cnt_r   <= cnt_new;
          default: begin
          end
        endcase
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    st_r      <= st_nxt;
    key_r     <= key_nxt;
    ins_val_r <= ins_val_nxt;
    ev_val_r  <= ev_val_nxt;
    evict_r   <= evict_nxt;
    j_r       <= j_nxt;
    rd_j_r    <= rd_j_nxt;
    place_r   <= place_nxt;
  end

  // Outputs.
  always_comb begin
    busy          = (state_r != ST_IDLE);
    out_strobe    = (state_r == ST_DONE);
    out_hit       = (place_r != PLACE_MISS);
    out_hit_place = place_r;
  end

  `TQC_ASSERT(a_fresh_cnt_max, fresh_cnt_r <= IDX_W'(FRESH_DEPTH), "first-time count overflow")
  `TQC_ASSERT(a_hot_cnt_max, hot_cnt_r <= IDX_W'(HOT_DEPTH), "hot count overflow")
  `TQC_ASSERT(a_accept_busy, (start && !busy) |=> busy, "accepted word did not raise busy")
  `TQC_ASSERT(a_done_idle, out_strobe |=> !busy, "result not followed by idle")
  `TQC_ASSERT(a_rd_src, rd_v_r |-> $past(mem_re), "stray read")
  `TQC_ASSERT_ALWAYS(a_rst_idle, !rst_n |=> !busy, "reset left block busy")

endmodule
